### hw/rtl/mroe_pkg.sv
package mroe_pkg;

  localparam int MAX_ROWS  = 16;
  localparam int MAX_COLS  = 16;
  localparam int FRAC_BITS = 16;

  localparam int DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int ROW_IW  = $clog2(MAX_ROWS);
  localparam int COL_IW  = $clog2(MAX_COLS);
  localparam int CNT_W   = 5;
  localparam int IDX_W   = 5;
  localparam int DATA_W  = 32;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int STAT_W  = 2;
  localparam int ACT_W   = 3;

  localparam int IN_FIELDS_W = ACT_W + 3 * IDX_W + 2 * DATA_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = DATA_W + STAT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD      = OUT_TDATA_W - OUT_FIELDS_W;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IDX = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IDX = 1'b1;

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE     = 3'd0,
    ACT_READ      = 3'd1,
    ACT_ADD       = 3'd2,
    ACT_SUB       = 3'd3,
    ACT_SWAP      = 3'd4,
    ACT_SCALE_ROW = 3'd5,
    ACT_PIVOT     = 3'd6,
    ACT_SCALE_ALL = 3'd7
  } act_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_IDX  = 2'd1,
    STAT_ZERO_FAC = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic                     valid;
    act_t                     act;
    logic [DATA_W-1:0]        q0;
    logic [DATA_W-1:0]        q1;
    logic [DATA_W-1:0]        value;
    logic signed [PROD_W-1:0] prod;
  } wb_in_t;

  typedef struct packed {
    logic              we;
    logic              use_b;
    logic [DATA_W-1:0] wdata;
  } wb_out_t;

endpackage

### hw/rtl/mroe_wb_alu.sv
module mroe_wb_alu (
  input  mroe_pkg::wb_in_t  wb_in,
  output mroe_pkg::wb_out_t wb_out
);
  import mroe_pkg::*;

  localparam int SUM_W = PROD_W + 1;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sh7fffffff);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(64'sh80000000);

  function automatic logic [DATA_W-1:0] sat(input logic signed [SUM_W-1:0] v);
    logic [DATA_W-1:0] r;
    if (v > SAT_HI) r = {1'b0, {(DATA_W-1){1'b1}}};
    else if (v < SAT_LO) r = {1'b1, {(DATA_W-1){1'b0}}};
    else r = v[DATA_W-1:0];
    return r;
  endfunction

  logic signed [PROD_W-1:0] sh;
  logic signed [SUM_W-1:0]  sh_x;
  logic signed [SUM_W-1:0]  q0_x;
  logic signed [SUM_W-1:0]  q1_x;
  logic signed [SUM_W-1:0]  val_x;

  always_comb begin
    // arithmetic shift floors, matching the product rounding
    sh    = wb_in.prod >>> FRAC_BITS;
    sh_x  = {sh[PROD_W-1], sh};
    q0_x  = {{(SUM_W-DATA_W){wb_in.q0[DATA_W-1]}}, wb_in.q0};
    q1_x  = {{(SUM_W-DATA_W){wb_in.q1[DATA_W-1]}}, wb_in.q1};
    val_x = {{(SUM_W-DATA_W){wb_in.value[DATA_W-1]}}, wb_in.value};

    wb_out.we    = wb_in.valid;
    wb_out.use_b = 1'b0;
    wb_out.wdata = wb_in.value;
    unique case (wb_in.act)
      ACT_WRITE: wb_out.wdata = wb_in.value;
      ACT_READ:  wb_out.we = 1'b0;
      ACT_ADD:   wb_out.wdata = sat(q0_x + val_x);
      ACT_SUB:   wb_out.wdata = sat(q0_x - val_x);
      ACT_SWAP:  wb_out.wdata = wb_in.q1;
      ACT_SCALE_ROW, ACT_SCALE_ALL: wb_out.wdata = sat(sh_x);
      ACT_PIVOT: begin
        wb_out.use_b = 1'b1;
        wb_out.wdata = sat(sh_x + q1_x);
      end
      default: wb_out.we = 1'b0;
    endcase
  end

endmodule

### hw/rtl/matrix_row_operation_engine_core.sv
// Channel | Direction | Handshake            | Payload
// in      | slave     | in_tvalid/in_tready   | in_tdata: action, row_a, row_b, col, value, factor
// out     | master    | out_tvalid/out_tready | out_tdata: read_value, status
// cfg     | write     | cfg_we                | cfg_addr, cfg_wdata
//
// One item at a time. Elements walk a read, multiply, write-back pipeline fed by the
// dual-read, single-write element memory; a swap makes two writes per column on the single
// write port. After reset a clearing pass writes zero to all 256 entries, one per cycle; no
// request is taken meanwhile. A finished result waits in the output register while the next
// request is accepted; a full output register holds the engine at the end of its item.
module matrix_row_operation_engine_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // action[2:0], row_a[7:3], row_b[12:8], col[17:13], value[49:18], factor[81:50]
  input  logic [mroe_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // read_value[31:0], status[33:32]
  output logic [mroe_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_we,
  input  logic [mroe_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [mroe_pkg::CNT_W-1:0]          cfg_wdata
);
  import mroe_pkg::*;

  function automatic logic [ADDR_W-1:0] elem_addr(input logic [ROW_IW-1:0] r,
                                                  input logic [COL_IW-1:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
  endfunction

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] rows_r, cols_r;
  logic [CNT_W-1:0] eff_rows, eff_cols;

  // request fields
  act_t              in_act;
  logic [IDX_W-1:0]  in_ra, in_rb, in_col;
  logic [DATA_W-1:0] in_val, in_fac;
  logic [IDX_W-1:0]  ra_m1, rb_m1, col_m1;
  logic [CNT_W-1:0]  nr_m1, nc_m1;
  logic              ra_ok, rb_ok, col_ok;
  logic              walk;
  stat_t             stat_dec;

  // item state
  act_t              act_r;
  stat_t             status_r;
  logic [DATA_W-1:0] val_r;
  logic signed [DATA_W-1:0] fac_r;
  logic [ROW_IW-1:0] row_r, row_last_r, rb_r;
  logic [COL_IW-1:0] col_r, col_last_r;
  logic              phase_r;
  logic [DATA_W-1:0] rdval_r;

  // control
  logic in_acc, issue_go, issue_last, pipe_empty, out_load, clr_we, clr_done;
  logic [ADDR_W-1:0] clr_cnt_r;

  // memory and pipeline
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] mq0_r, mq1_r;
  logic [ADDR_W-1:0] rd0_addr, rd1_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;

  logic              s1_v_r;
  logic [ADDR_W-1:0] s1_a0_r, s1_a1_r;
  logic              s2_v_r;
  logic [ADDR_W-1:0] s2_a0_r, s2_a1_r;
  logic [DATA_W-1:0] s2_q0_r, s2_q1_r;
  logic signed [PROD_W-1:0] prod_r;
  logic              s3_v_r;
  logic [ADDR_W-1:0] s3_a_r;
  logic [DATA_W-1:0] s3_d_r;

  wb_in_t  wb_in;
  wb_out_t wb_out;

  logic              out_tvalid_r;
  logic [DATA_W-1:0] out_rd_r;
  stat_t             out_status_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= CNT_W'(16);
      cols_r <= CNT_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ROWS_IDX: rows_r <= cfg_wdata;
        CFG_COLS_IDX: cols_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign eff_rows = (rows_r < CNT_W'(MAX_ROWS)) ? rows_r : CNT_W'(MAX_ROWS);
  assign eff_cols = (cols_r < CNT_W'(MAX_COLS)) ? cols_r : CNT_W'(MAX_COLS);

  // request decode
  always_comb begin
    in_act = act_t'(in_tdata[ACT_W-1:0]);
    in_ra  = in_tdata[ACT_W +: IDX_W];
    in_rb  = in_tdata[ACT_W+IDX_W +: IDX_W];
    in_col = in_tdata[ACT_W+2*IDX_W +: IDX_W];
    in_val = in_tdata[ACT_W+3*IDX_W +: DATA_W];
    in_fac = in_tdata[ACT_W+3*IDX_W+DATA_W +: DATA_W];
    ra_m1  = in_ra - IDX_W'(1);
    rb_m1  = in_rb - IDX_W'(1);
    col_m1 = in_col - IDX_W'(1);
    nr_m1  = eff_rows - CNT_W'(1);
    nc_m1  = eff_cols - CNT_W'(1);
    ra_ok  = (in_ra != '0) && (in_ra <= eff_rows);
    rb_ok  = (in_rb != '0) && (in_rb <= eff_rows);
    col_ok = (in_col != '0) && (in_col <= eff_cols);
    walk     = 1'b0;
    stat_dec = STAT_OK;
    unique case (in_act)
      ACT_WRITE, ACT_READ, ACT_ADD, ACT_SUB: begin
        walk     = ra_ok && col_ok;
        stat_dec = walk ? STAT_OK : STAT_BAD_IDX;
      end
      ACT_SWAP, ACT_PIVOT: begin
        walk     = ra_ok && rb_ok && (eff_cols != '0);
        stat_dec = (ra_ok && rb_ok) ? STAT_OK : STAT_BAD_IDX;
      end
      ACT_SCALE_ROW: begin
        walk     = ra_ok && (eff_cols != '0);
        stat_dec = ra_ok ? STAT_OK : STAT_BAD_IDX;
      end
      ACT_SCALE_ALL: begin
        walk     = (in_fac != '0) && (eff_rows != '0) && (eff_cols != '0);
        stat_dec = (in_fac != '0) ? STAT_OK : STAT_ZERO_FAC;
      end
      default: walk = 1'b0;
    endcase
  end

  assign issue_last = (col_r == col_last_r) && (row_r == row_last_r);
  assign pipe_empty = !s1_v_r && !s2_v_r && !s3_v_r;
  assign clr_done   = (clr_cnt_r == ADDR_W'(DEPTH - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_done) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_tvalid) state_nxt = walk ? ST_ISSUE : ST_DRAIN;
      ST_ISSUE: if (issue_go && issue_last) state_nxt = ST_DRAIN;
      ST_DRAIN: if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = 1'b0;
    issue_go  = 1'b0;
    out_load  = 1'b0;
    clr_we    = 1'b0;
    unique case (state_r)
      ST_CLEAR: clr_we = 1'b1;
      ST_IDLE:  in_tready = 1'b1;
      ST_ISSUE: issue_go = (act_r != ACT_SWAP) || !phase_r;
      ST_DRAIN: out_load = pipe_empty && (!out_tvalid_r || out_tready);
      default: ;
    endcase
  end

  assign in_acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clr_we) clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
    end
  end

  // item registers and walk counters
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r    <= in_act;
      status_r <= stat_dec;
      val_r    <= in_val;
      fac_r    <= in_fac;
      rb_r     <= rb_m1[ROW_IW-1:0];
      phase_r  <= 1'b0;
      rdval_r  <= '0;
      unique case (in_act)
        ACT_WRITE, ACT_READ, ACT_ADD, ACT_SUB: begin
          row_r      <= ra_m1[ROW_IW-1:0];
          row_last_r <= ra_m1[ROW_IW-1:0];
          col_r      <= col_m1[COL_IW-1:0];
          col_last_r <= col_m1[COL_IW-1:0];
        end
        ACT_SCALE_ALL: begin
          row_r      <= '0;
          row_last_r <= nr_m1[ROW_IW-1:0];
          col_r      <= '0;
          col_last_r <= nc_m1[COL_IW-1:0];
        end
        default: begin
          row_r      <= ra_m1[ROW_IW-1:0];
          row_last_r <= ra_m1[ROW_IW-1:0];
          col_r      <= '0;
          col_last_r <= nc_m1[COL_IW-1:0];
        end
      endcase
    end else begin
      if (state_r == ST_ISSUE) phase_r <= !phase_r;
      if (issue_go && !issue_last) begin
        if (col_r == col_last_r) begin
          col_r <= '0;
          row_r <= row_r + ROW_IW'(1);
        end else begin
          col_r <= col_r + COL_IW'(1);
        end
      end
      if (s2_v_r && (act_r == ACT_READ)) rdval_r <= s2_q0_r;
    end
  end

  assign rd0_addr = elem_addr(row_r, col_r);
  assign rd1_addr = elem_addr(rb_r, col_r);

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue_go;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r && (act_r == ACT_SWAP);
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    s1_a0_r <= rd0_addr;
    s1_a1_r <= rd1_addr;
    s2_a0_r <= s1_a0_r;
    s2_a1_r <= s1_a1_r;
    s2_q0_r <= mq0_r;
    s2_q1_r <= mq1_r;
    prod_r  <= PROD_W'(fac_r) * PROD_W'($signed(mq0_r));
    // second half of a swap: row b takes the old row a element
    s3_a_r  <= s2_a1_r;
    s3_d_r  <= s2_q0_r;
  end

  always_comb begin
    wb_in.valid = s2_v_r;
    wb_in.act   = act_r;
    wb_in.q0    = s2_q0_r;
    wb_in.q1    = s2_q1_r;
    wb_in.value = val_r;
    wb_in.prod  = prod_r;
  end

  mroe_wb_alu u_alu (
    .wb_in  (wb_in),
    .wb_out (wb_out)
  );

  always_comb begin
    if (clr_we) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else if (s3_v_r) begin
      mem_we    = 1'b1;
      mem_waddr = s3_a_r;
      mem_wdata = s3_d_r;
    end else begin
      mem_we    = wb_out.we;
      mem_waddr = wb_out.use_b ? s2_a1_r : s2_a0_r;
      mem_wdata = wb_out.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mq0_r <= mem[rd0_addr];
    mq1_r <= mem[rd1_addr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rd_r     <= rdval_r;
      out_status_r <= status_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, out_status_r, out_rd_r};

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mem_we)
    else $error("memory written while idle");

  a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r |-> !wb_out.we)
    else $error("swap write-back collides with stage two write");

  a_accept_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> pipe_empty)
    else $error("request accepted with elements in flight");

  a_load_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (state_r == ST_DRAIN) && !issue_go)
    else $error("result loaded before the walk finished");

endmodule

### tb/sv/matrix_row_operation_engine_core_checker.sv
module matrix_row_operation_engine_core_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  // action[2:0], row_a[7:3], row_b[12:8], col[17:13], value[49:18], factor[81:50]
  input  logic [mroe_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  // read_value[31:0], status[33:32]
  input  logic [mroe_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_we,
  input  logic [mroe_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [mroe_pkg::CNT_W-1:0]       cfg_wdata,
  output int                               fail_count,
  output int                               pending_results
);
  import mroe_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    stat_t             status;
  } answer_t;

  answer_t                  answers [$];
  answer_t                  want_answer;
  answer_t                  got_answer;
  logic signed [DATA_W-1:0] cells [DEPTH];
  logic [CNT_W-1:0]         rows_set;
  logic [CNT_W-1:0]         cols_set;
  int                       failures;
  int unsigned              result_no;

  function automatic logic [DATA_W-1:0] clamp32(input longint v);
    if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'h8000_0000;
    return v[DATA_W-1:0];
  endfunction

  // Q16.16 product, shifted down with rounding toward minus infinity
  function automatic longint qmul(input logic signed [DATA_W-1:0] a,
                                  input logic signed [DATA_W-1:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> FRAC_BITS;
  endfunction

  function automatic int unsigned live_rows();
    return (rows_set < CNT_W'(MAX_ROWS)) ? 32'(rows_set) : 32'(MAX_ROWS);
  endfunction

  function automatic int unsigned live_cols();
    return (cols_set < CNT_W'(MAX_COLS)) ? 32'(cols_set) : 32'(MAX_COLS);
  endfunction

  function automatic bit in_range(input int unsigned idx, input int unsigned n);
    return idx >= 1 && idx <= n;
  endfunction

  function automatic logic [ADDR_W-1:0] slot(input int unsigned r, input int unsigned c);
    return ADDR_W'((r - 1) * MAX_COLS + (c - 1));
  endfunction

  // Apply one request to the matrix copy and return its answer
  function automatic answer_t apply_request(input logic [IN_TDATA_W-1:0] td);
    act_t                     act;
    int unsigned              ra, rb, cl, nr, nc, r, c;
    logic signed [DATA_W-1:0] val, fac, tmp;
    answer_t                  ans;
    act = act_t'(td[2:0]);
    ra  = 32'(td[7:3]);
    rb  = 32'(td[12:8]);
    cl  = 32'(td[17:13]);
    val = td[49:18];
    fac = td[81:50];
    nr  = live_rows();
    nc  = live_cols();
    ans.read_value = '0;
    ans.status     = STAT_OK;
    case (act)
      ACT_WRITE, ACT_READ, ACT_ADD, ACT_SUB: begin
        if (!in_range(ra, nr) || !in_range(cl, nc)) begin
          ans.status = STAT_BAD_IDX;
        end else if (act == ACT_WRITE) begin
          cells[slot(ra, cl)] = val;
        end else if (act == ACT_READ) begin
          ans.read_value = cells[slot(ra, cl)];
        end else if (act == ACT_ADD) begin
          cells[slot(ra, cl)] = clamp32(longint'(cells[slot(ra, cl)]) + longint'(val));
        end else begin
          cells[slot(ra, cl)] = clamp32(longint'(cells[slot(ra, cl)]) - longint'(val));
        end
      end
      ACT_SWAP: begin
        if (!in_range(ra, nr) || !in_range(rb, nr)) begin
          ans.status = STAT_BAD_IDX;
        end else begin
          for (c = 1; c <= nc; c++) begin
            tmp = cells[slot(ra, c)];
            cells[slot(ra, c)] = cells[slot(rb, c)];
            cells[slot(rb, c)] = tmp;
          end
        end
      end
      ACT_SCALE_ROW: begin
        if (!in_range(ra, nr)) begin
          ans.status = STAT_BAD_IDX;
        end else begin
          for (c = 1; c <= nc; c++)
            cells[slot(ra, c)] = clamp32(qmul(fac, cells[slot(ra, c)]));
        end
      end
      ACT_PIVOT: begin
        if (!in_range(ra, nr) || !in_range(rb, nr)) begin
          ans.status = STAT_BAD_IDX;
        end else begin
          // sum at full width, saturate once
          for (c = 1; c <= nc; c++)
            cells[slot(rb, c)] = clamp32(qmul(fac, cells[slot(ra, c)])
                                         + longint'(cells[slot(rb, c)]));
        end
      end
      default: begin
        if (fac == 0) begin
          ans.status = STAT_ZERO_FAC;
        end else begin
          for (r = 1; r <= nr; r++)
            for (c = 1; c <= nc; c++)
              cells[slot(r, c)] = clamp32(qmul(fac, cells[slot(r, c)]));
        end
      end
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (cells[i]) cells[i] = '0;
      rows_set = 5'd16;
      cols_set = 5'd16;
      answers.delete();
    end else begin
      // retire the answer before queuing a new request from the same edge
      if (out_tvalid && out_tready) begin
        result_no++;
        got_answer.read_value = out_tdata[DATA_W-1:0];
        got_answer.status     = stat_t'(out_tdata[DATA_W+STAT_W-1:DATA_W]);
        if (answers.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("result %0d: unexpected, read_value %h status %0d",
                     result_no, got_answer.read_value, got_answer.status);
        end else begin
          want_answer = answers.pop_front();
          if (got_answer.read_value !== want_answer.read_value ||
              got_answer.status !== want_answer.status) begin
            failures++;
            if (failures <= 10)
              $display("result %0d: read_value exp %h got %h, status exp %0d got %0d",
                       result_no, want_answer.read_value, got_answer.read_value,
                       want_answer.status, got_answer.status);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_addr == CFG_ROWS_IDX) rows_set = cfg_wdata;
        else if (cfg_addr == CFG_COLS_IDX) cols_set = cfg_wdata;
      end
      if (in_tvalid && in_tready) answers.push_back(apply_request(in_tdata));
    end
    pending_results <= answers.size();
    fail_count      <= failures;
  end

endmodule

### tb/sv/matrix_row_operation_engine_core_tb.sv
module matrix_row_operation_engine_core_tb;
  import mroe_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS = 60;

  localparam logic [DATA_W-1:0] Q_ONE       = 32'h0001_0000;
  localparam logic [DATA_W-1:0] Q_MINUS_ONE = 32'hFFFF_0000;
  localparam logic [DATA_W-1:0] Q_MINUS_TWO = 32'hFFFE_0000;
  localparam logic [DATA_W-1:0] Q_HALF      = 32'h0000_8000;
  localparam logic [DATA_W-1:0] Q_MAX       = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] Q_MIN       = 32'h8000_0000;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_addr;
  logic [CNT_W-1:0]       cfg_wdata;

  int          fail_count;
  int          pending_results;
  int unsigned quiet_cycles;
  int unsigned burst_left;
  bit          sender_gaps;
  int unsigned hold_req;
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned mode_left;
  int unsigned rx_mode;

  int unsigned phase_rows [10] = '{4, 1, 31, 0, 6, 16, 3, 16, 2, 5};
  int unsigned phase_cols [10] = '{4, 1, 31, 5, 0, 16, 7, 1, 16, 5};

  matrix_row_operation_engine_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  matrix_row_operation_engine_core_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic logic [IN_TDATA_W-1:0] pack_request(
    input act_t act, input logic [IDX_W-1:0] ra, input logic [IDX_W-1:0] rb,
    input logic [IDX_W-1:0] cl, input logic [DATA_W-1:0] val,
    input logic [DATA_W-1:0] fac);
    logic [IN_TDATA_W-1:0] w;
    w = '0;
    w[81:0] = {fac, val, cl, rb, ra, act};
    return w;
  endfunction

  function automatic logic [DATA_W-1:0] rand_value();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = Q_MAX;
      1: v = Q_MIN;
      2, 3: v = $urandom;
      default: begin
        v = $urandom_range(0, 32'h0008_0000);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [DATA_W-1:0] rand_factor();
    logic [DATA_W-1:0] f;
    case ($urandom_range(0, 9))
      0: f = '0;
      1: f = Q_ONE;
      2: f = Q_MINUS_ONE;
      3: f = $urandom;
      4: f = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      default: begin
        f = $urandom_range(0, 32'h0003_0000);
        if ($urandom_range(0, 1)) f = -f;
      end
    endcase
    return f;
  endfunction

  // mostly in range; now and then any 5-bit index
  function automatic logic [IDX_W-1:0] pick_index(input int unsigned n);
    if (n == 0 || $urandom_range(0, 9) == 0) return IDX_W'($urandom_range(0, 31));
    return IDX_W'($urandom_range(1, n));
  endfunction

  function automatic logic [IN_TDATA_W-1:0] random_request(input int unsigned rows,
                                                           input int unsigned cols);
    int unsigned nr, nc, w;
    act_t        act;
    nr = (rows < MAX_ROWS) ? rows : MAX_ROWS;
    nc = (cols < MAX_COLS) ? cols : MAX_COLS;
    w  = $urandom_range(0, 99);
    if (w < 22)      act = ACT_WRITE;
    else if (w < 44) act = ACT_READ;
    else if (w < 54) act = ACT_ADD;
    else if (w < 64) act = ACT_SUB;
    else if (w < 72) act = ACT_SWAP;
    else if (w < 80) act = ACT_SCALE_ROW;
    else if (w < 97) act = ACT_PIVOT;
    else             act = ACT_SCALE_ALL;
    return pack_request(act, pick_index(nr), pick_index(nr), pick_index(nc),
                        rand_value(), rand_factor());
  endfunction

  task automatic send_request(input logic [IN_TDATA_W-1:0] req);
    int unsigned gap;
    if (sender_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 12);
      burst_left = $urandom_range(1, 16);
      @(negedge clk) in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= req;
    do @(posedge clk); while (in_tready !== 1'b1);
    if (burst_left > 0) burst_left--;
  endtask

  // drop valid and wait for every outstanding request to answer
  task automatic drain_results();
    @(negedge clk) in_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  // receiver: own stall pattern, plus a long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (rx_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 9) < 7);
          2: out_tready <= ($urandom_range(0, 9) < 3);
          default: out_tready <= mode_left[1];
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("matrix_row_operation_engine_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int unsigned ph, k;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_we      = 1'b0;
    cfg_addr    = CFG_ROWS_IDX;
    cfg_wdata   = '0;
    sender_gaps = 1'b1;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // directed requests at the reset size of 16 x 16
    send_request(pack_request(ACT_WRITE, 1, 0, 1, Q_MAX, '0));
    send_request(pack_request(ACT_WRITE, 16, 0, 16, Q_MIN, '0));
    send_request(pack_request(ACT_READ, 1, 0, 1, '0, '0));
    send_request(pack_request(ACT_READ, 16, 0, 16, '0, '0));
    send_request(pack_request(ACT_ADD, 1, 0, 1, Q_ONE, '0));
    send_request(pack_request(ACT_SUB, 16, 0, 16, Q_ONE, '0));
    send_request(pack_request(ACT_WRITE, 2, 0, 3, 32'h0001_8000, '0));
    send_request(pack_request(ACT_READ, 0, 0, 1, '0, '0));
    send_request(pack_request(ACT_WRITE, 17, 0, 1, Q_ONE, '0));
    send_request(pack_request(ACT_READ, 31, 31, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(pack_request(ACT_ADD, 1, 0, 31, Q_ONE, '0));
    send_request(pack_request(ACT_SWAP, 1, 2, 0, '0, '0));
    send_request(pack_request(ACT_SWAP, 2, 2, 0, '0, '0));
    send_request(pack_request(ACT_SWAP, 0, 2, 0, '0, '0));
    send_request(pack_request(ACT_SCALE_ROW, 1, 0, 0, '0, Q_MINUS_TWO));
    send_request(pack_request(ACT_SCALE_ROW, 2, 0, 0, '0, '0));
    send_request(pack_request(ACT_SCALE_ROW, 17, 0, 0, '0, Q_ONE));
    send_request(pack_request(ACT_PIVOT, 1, 16, 0, '0, Q_HALF));
    send_request(pack_request(ACT_PIVOT, 16, 16, 0, '0, Q_ONE));
    send_request(pack_request(ACT_PIVOT, 1, 0, 0, '0, Q_ONE));
    send_request(pack_request(ACT_SCALE_ALL, 0, 0, 0, '0, '0));
    send_request(pack_request(ACT_SCALE_ALL, 0, 0, 0, '0, Q_MINUS_ONE));
    send_request(pack_request(ACT_READ, 16, 0, 16, '0, '0));
    send_request(pack_request(ACT_READ, 1, 0, 2, '0, '0));

    for (ph = 0; ph < 10; ph++) begin
      drain_results();
      write_reg(CFG_ROWS_IDX, CNT_W'(phase_rows[ph]));
      write_reg(CFG_COLS_IDX, CNT_W'(phase_cols[ph]));
      sender_gaps = (ph % 3 != 1);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // hold the receiver off while requests keep coming
        if (k == 10 && (ph == 0 || ph == 5)) hold_req++;
        if (k == PHASE_ITEMS / 2 && ph % 2 == 1) drain_results();
        send_request(random_request(phase_rows[ph], phase_cols[ph]));
      end
    end

    drain_results();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending_results == 0)
      $display("matrix_row_operation_engine_core: match");
    else
      $display("matrix_row_operation_engine_core: mismatch");
    $finish;
  end

endmodule

### sim.f
hw/rtl/mroe_pkg.sv
hw/rtl/mroe_wb_alu.sv
hw/rtl/matrix_row_operation_engine_core.sv
tb/sv/matrix_row_operation_engine_core_checker.sv
tb/sv/matrix_row_operation_engine_core_tb.sv
